@@ src/dbar_pkg.sv @@
// Shared types and constants for the debounced button auto-repeat block.
`default_nettype none
package dbar_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int BTN_AW      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int IDX_W       = 2;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int DIV_STEPS   = TIME_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;
    localparam int REG_IDX_W   = 3;

    // Register indexes; byte address is 4 * index.
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INIT_HOLD = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ACCEL = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SLOW = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FAST = 3'd4;

    localparam logic [CFG_W-1:0] RST_DEBOUNCE  = 16'd50;
    localparam logic [CFG_W-1:0] RST_INIT_HOLD = 16'd500;
    localparam logic [CFG_W-1:0] RST_ACCEL     = 16'd2000;
    localparam logic [CFG_W-1:0] RST_SLOW      = 16'd200;
    localparam logic [CFG_W-1:0] RST_FAST      = 16'd20;

    typedef struct packed {
        logic [IDX_W-1:0]  button_index;
        logic              raw_level;
        logic [TIME_W-1:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] button_id;
        logic             fire;
        logic             debounced_pressed;
    } t_out_word;

    // One button's state as it sits in the state memory.
    typedef struct packed {
        logic [TIME_W-1:0] last_change;
        logic [TIME_W-1:0] press_start;
        logic [TIME_W-1:0] last_fire;
        logic              stable;
        logic              holding;
    } t_entry;

    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] init_hold;
        logic [CFG_W-1:0] accel;
        logic [CFG_W-1:0] slow;
        logic [CFG_W-1:0] fast;
    } t_cfg;

endpackage
`default_nettype wire

@@ src/debounced_button_auto_repeat.sv @@
// Debounced active-low buttons with accelerating auto-repeat: top level and sequencer.
//
// Input channel (i_in_valid / o_in_ready, word i_in_word): one sample of one
// button with its millisecond timestamp. Output channel (o_out_valid /
// i_out_ready, word o_out_word): exactly one result word per input word, in
// order: button id, fire flag and the debounced level.
// Per-button state lives in a small synchronous memory that is read when a
// word is taken and written back when its result is produced.
// Flow: one word at a time. When the repeat interval must shrink during
// acceleration, the 32-step divider works it out in S_START and S_DIV.
// The result is registered into the output register from S_DONE, after
// S_EVAL and S_HOLD (and S_START and S_DIV when the divider runs).
// A new word is taken while a result still waits in the output register; a
// stalled receiver holds the sequencer at write-back once a second result is
// ready.
// Reset: all button state reads as released with zero timestamps, and the
// timing registers return to their defaults. The user must write settings (APB,
// 4-byte stride) only while no word is in flight; the block does not enforce it.
`default_nettype none
module debounced_button_auto_repeat (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  dbar_pkg::t_in_word          i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output dbar_pkg::t_out_word         o_out_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dbar_pkg::APB_AW-1:0] paddr,
    input  logic [dbar_pkg::APB_DW-1:0] pwdata,
    output logic [dbar_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import dbar_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_HOLD  = 6'b000100,
        S_START = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    t_cfg              w_cfg;
    t_in_word          r_item;
    t_entry            w_rd_ent;
    t_entry            r_ent, n_ent;
    t_entry            w_wr_ent;
    t_out_word         r_out_word;
    logic              r_out_valid;
    logic [TIME_W-1:0] r_since;
    logic [CFG_W-1:0]  r_span;
    logic [CFG_W-1:0]  r_range;
    logic              r_need_div;
    logic              r_no_rep;
    logic              w_in_acc;
    logic              w_oor;
    logic              w_out_free;
    logic              w_finish;
    logic              w_pressed_now;
    logic [TIME_W-1:0] w_hold;
    logic [TIME_W-1:0] w_since;
    logic [TIME_W-1:0] w_span;
    logic              w_no_rep;
    logic              w_need_div;
    logic [TIME_W-1:0] w_product;
    logic              w_div_done;
    logic [CFG_W-1:0]  w_quot;
    logic [CFG_W-1:0]  w_interval;
    logic              w_due;
    logic              w_fire;

    dbar_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dbar_state_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (BTN_AW'(i_in_word.button_index)),
        .o_rd_data (w_rd_ent),
        .i_wr_en   (w_finish & ~w_oor),
        .i_wr_addr (BTN_AW'(r_item.button_index)),
        .i_wr_data (w_wr_ent)
    );

    assign w_product = TIME_W'(r_range) * TIME_W'(r_span);

    dbar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_dividend (w_product),
        .i_divisor  (w_cfg.accel),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign o_in_ready    = (r_state == S_IDLE);
    assign w_in_acc      = i_in_valid & o_in_ready;
    assign w_oor         = 32'(r_item.button_index) >= NUM_BUTTONS;
    assign w_out_free    = ~r_out_valid | i_out_ready;
    assign w_finish      = (r_state == S_DONE) & w_out_free;
    assign w_pressed_now = ~r_item.raw_level;

    // Debounce against the entry just read.
    always_comb begin
        n_ent = w_rd_ent;
        if (w_pressed_now != w_rd_ent.stable) begin
            if ((r_item.now_ms - w_rd_ent.last_change) >= TIME_W'(w_cfg.debounce)) begin
                n_ent.stable      = w_pressed_now;
                n_ent.last_change = r_item.now_ms;
                n_ent.holding     = 1'b0;
                if (w_pressed_now) begin
                    n_ent.press_start = r_item.now_ms;
                    n_ent.last_fire   = r_item.now_ms;
                end
            end
        end else begin
            n_ent.last_change = r_item.now_ms;
        end
    end

    // Hold time and where in the acceleration ramp the button is.
    assign w_hold     = r_item.now_ms - r_ent.press_start;
    assign w_since    = r_item.now_ms - r_ent.last_fire;
    assign w_no_rep   = w_hold < TIME_W'(w_cfg.init_hold);
    assign w_span     = w_hold - TIME_W'(w_cfg.init_hold);
    assign w_need_div = r_ent.stable & r_ent.holding & ~w_no_rep
                      & (w_span < TIME_W'(w_cfg.accel)) & (w_cfg.slow >= w_cfg.fast);

    // Repeat decision and write-back.
    assign w_interval = r_need_div ? (w_cfg.slow - w_quot) : w_cfg.fast;
    assign w_due      = ~r_no_rep & (r_since >= TIME_W'(w_interval));
    assign w_fire     = ~w_oor & r_ent.stable & (~r_ent.holding | w_due);

    always_comb begin
        w_wr_ent = r_ent;
        if (r_ent.stable) begin
            w_wr_ent.holding = 1'b1;
        end
        if (w_fire) begin
            w_wr_ent.last_fire = r_item.now_ms;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = w_oor ? S_DONE : S_HOLD;
            end
            S_HOLD: begin
                n_state = w_need_div ? S_START : S_DONE;
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_need_div  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_EVAL) begin
                r_need_div <= 1'b0;
            end else if (r_state == S_HOLD) begin
                r_need_div <= w_need_div;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= i_in_word;
        end
        if (r_state == S_EVAL) begin
            r_ent <= n_ent;
        end
        if (r_state == S_HOLD) begin
            r_since  <= w_since;
            r_no_rep <= w_no_rep;
            r_span   <= w_span[CFG_W-1:0];
            r_range  <= w_cfg.slow - w_cfg.fast;
        end
        if (w_finish) begin
            r_out_word.button_id         <= r_item.button_index;
            r_out_word.fire              <= w_fire;
            r_out_word.debounced_pressed <= ~w_oor & r_ent.stable;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire

@@ src/dbar_cfg.sv @@
// APB register file holding the debounce and repeat timing settings.
`default_nettype none
module dbar_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dbar_pkg::APB_AW-1:0] paddr,
    input  logic [dbar_pkg::APB_DW-1:0] pwdata,
    output logic [dbar_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output dbar_pkg::t_cfg              o_cfg
);
    import dbar_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[APB_AW-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce  <= RST_DEBOUNCE;
            r_cfg.init_hold <= RST_INIT_HOLD;
            r_cfg.accel     <= RST_ACCEL;
            r_cfg.slow      <= RST_SLOW;
            r_cfg.fast      <= RST_FAST;
        end else if (w_wr) begin
            case (w_idx)
                REG_DEBOUNCE:  r_cfg.debounce  <= pwdata[CFG_W-1:0];
                REG_INIT_HOLD: r_cfg.init_hold <= pwdata[CFG_W-1:0];
                REG_ACCEL:     r_cfg.accel     <= pwdata[CFG_W-1:0];
                REG_SLOW:      r_cfg.slow      <= pwdata[CFG_W-1:0];
                REG_FAST:      r_cfg.fast      <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DEBOUNCE:  prdata = {{(APB_DW-CFG_W){1'b0}}, r_cfg.debounce};
            REG_INIT_HOLD: prdata = {{(APB_DW-CFG_W){1'b0}}, r_cfg.init_hold};
            REG_ACCEL:     prdata = {{(APB_DW-CFG_W){1'b0}}, r_cfg.accel};
            REG_SLOW:      prdata = {{(APB_DW-CFG_W){1'b0}}, r_cfg.slow};
            REG_FAST:      prdata = {{(APB_DW-CFG_W){1'b0}}, r_cfg.fast};
            default:       prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ src/dbar_state_mem.sv @@
// Per-button state memory: registered synchronous read, entries read as zero until written.
`default_nettype none
module dbar_state_mem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [dbar_pkg::BTN_AW-1:0] i_rd_addr,
    output dbar_pkg::t_entry            o_rd_data,
    input  logic                        i_wr_en,
    input  logic [dbar_pkg::BTN_AW-1:0] i_wr_addr,
    input  dbar_pkg::t_entry            i_wr_data
);
    import dbar_pkg::*;

    t_entry                 mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_vld;
    t_entry                 r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // Unwritten entries hold the reset state.
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
`default_nettype wire

@@ src/dbar_div.sv @@
// Restoring divider, one quotient bit per cycle, for the repeat interval cut.
`default_nettype none
module dbar_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dbar_pkg::TIME_W-1:0] i_dividend,
    input  logic [dbar_pkg::CFG_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [dbar_pkg::CFG_W-1:0]  o_quotient
);
    import dbar_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CFG_W-1:0]     r_rem;
    logic [TIME_W-1:0]    r_quo;
    logic [CFG_W-1:0]     r_dvs;
    logic [CFG_W:0]       w_shift;
    logic [CFG_W:0]       w_diff;
    logic                 w_ge;

    assign w_shift = {r_rem, r_quo[TIME_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = ~w_diff[CFG_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            // Remainder stays below the divisor, so it fits the divisor width.
            r_rem <= w_ge ? w_diff[CFG_W-1:0] : w_shift[CFG_W-1:0];
            r_quo <= {r_quo[TIME_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[CFG_W-1:0];

endmodule
`default_nettype wire
